[sv/llpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llpm_pkg
// Request and status codes, microcode step names and the control word of the
// linked list pool manager, together with its control store.
// ----------------------------------------------------------------------------
package llpm_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_INSERT     = 3'd2,
		REQ_ERASE      = 3'd3,
		REQ_CLEAR      = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_POOL_EMPTY = 2'd1,
		ST_BAD_POS    = 2'd2
	} status_t;

	// control store addresses
	typedef enum logic [2:0] {
		STEP_LINK_RD  = 3'd0,
		STEP_LINK_W1  = 3'd1,
		STEP_LINK_W2  = 3'd2,
		STEP_ERASE_RD = 3'd3,
		STEP_ERASE_W1 = 3'd4,
		STEP_ERASE_W2 = 3'd5,
		STEP_CLEAR    = 3'd6,
		STEP_REPORT   = 3'd7
	} step_t;

	typedef enum logic {NRD_FREE, NRD_AT} nrd_src_t;

	typedef enum logic [2:0] {
		NWA_NONE, NWA_PREV_RD, NWA_NEW, NWA_AT, NWA_TAIL
	} nw_addr_t;

	typedef enum logic [1:0] {NWD_NEW, NWD_AT, NWD_NEXT_RD, NWD_FREE} nw_data_t;

	typedef enum logic [1:0] {PWA_NONE, PWA_NEW, PWA_AT, PWA_NEXT_RD} pw_addr_t;

	typedef enum logic {PWD_PREV_RD, PWD_NEW} pw_data_t;

	typedef enum logic [1:0] {FH_HOLD, FH_NEXT_RD, FH_AT, FH_HEAD} free_op_t;

	typedef enum logic [1:0] {SZ_HOLD, SZ_INC, SZ_DEC, SZ_ZERO} size_op_t;

	typedef enum logic [1:0] {LV_HOLD, LV_SET_NEW, LV_CLR_AT, LV_CLR_ALL} live_op_t;

	typedef enum logic [1:0] {ND_HOLD, ND_NEW, ND_NEXT_RD} node_op_t;

	typedef struct packed {
		logic     rd;        // issue link reads
		nrd_src_t nrd_src;   // next link read address
		logic     take;      // pop the free list head into the new node
		nw_addr_t nw_addr;
		nw_data_t nw_data;
		pw_addr_t pw_addr;
		pw_data_t pw_data;
		free_op_t free_op;
		size_op_t size_op;
		live_op_t live_op;
		node_op_t node_op;
		logic     sent_rst;  // sentinel back to itself
		logic     last;      // final step, result goes out
	} ucw_t;

	function automatic ucw_t ucode(step_t s);
		ucw_t w;
		w = '0;
		case (s)
			STEP_LINK_RD: begin
				w.rd      = 1'b1;
				w.nrd_src = NRD_FREE;
				w.take    = 1'b1;
			end
			STEP_LINK_W1: begin
				w.nw_addr = NWA_PREV_RD;
				w.nw_data = NWD_NEW;
				w.pw_addr = PWA_NEW;
				w.pw_data = PWD_PREV_RD;
				w.free_op = FH_NEXT_RD;
			end
			STEP_LINK_W2: begin
				w.nw_addr = NWA_NEW;
				w.nw_data = NWD_AT;
				w.pw_addr = PWA_AT;
				w.pw_data = PWD_NEW;
				w.size_op = SZ_INC;
				w.live_op = LV_SET_NEW;
				w.node_op = ND_NEW;
				w.last    = 1'b1;
			end
			STEP_ERASE_RD: begin
				w.rd      = 1'b1;
				w.nrd_src = NRD_AT;
			end
			STEP_ERASE_W1: begin
				w.nw_addr = NWA_PREV_RD;
				w.nw_data = NWD_NEXT_RD;
				w.pw_addr = PWA_NEXT_RD;
				w.pw_data = PWD_PREV_RD;
			end
			STEP_ERASE_W2: begin
				w.nw_addr = NWA_AT;
				w.nw_data = NWD_FREE;
				w.free_op = FH_AT;
				w.size_op = SZ_DEC;
				w.live_op = LV_CLR_AT;
				w.node_op = ND_NEXT_RD;
				w.last    = 1'b1;
			end
			STEP_CLEAR: begin
				w.nw_addr  = NWA_TAIL;
				w.nw_data  = NWD_FREE;
				w.free_op  = FH_HEAD;
				w.size_op  = SZ_ZERO;
				w.live_op  = LV_CLR_ALL;
				w.sent_rst = 1'b1;
				w.last     = 1'b1;
			end
			STEP_REPORT: begin
				w.last = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

[sv/llpm_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llpm_req_if
// Request channel of the pool manager: request code and node position.
// ----------------------------------------------------------------------------
interface llpm_req_if #(
	parameter int IDX_W = 9
);
	logic             valid;
	logic             ready;
	logic [2:0]       req_type;
	logic [IDX_W-1:0] position;

	modport source (output valid, req_type, position, input ready);
	modport sink   (input valid, req_type, position, output ready);
endinterface

[sv/llpm_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llpm_rsp_if
// Result channel of the pool manager: node, list size and status.
// ----------------------------------------------------------------------------
interface llpm_rsp_if #(
	parameter int IDX_W = 9
);
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] node;
	logic [IDX_W-1:0] size;
	logic [1:0]       status;

	modport source (output valid, node, size, status, input ready);
	modport sink   (input valid, node, size, status, output ready);
endinterface

[sv/linked_list_pool_manager_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_pool_manager_unit
// Pool of NODES nodes kept as a circular doubly linked list with a sentinel
// (index NODES) and a singly linked free list, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents                 handshake
//  req      in   req_type, position            valid / ready
//  rsp      out  node, size, status            valid / ready
//
//  push and insert run LINK_RD, LINK_W1 and LINK_W2, erase runs ERASE_RD,
//  ERASE_W1 and ERASE_W2, clear runs CLEAR, rejected or unused requests
//  REPORT: a link memory has one write port, a link op writes two in each.
//  req is taken whenever the sequencer is idle, also while a result waits.
//  a finishing step holds while the result register is still full.
//  reset needs no clearing pass: free nodes never handed out yet are tracked
//  by a fill count, and the sentinel links live in registers.
// ----------------------------------------------------------------------------
module linked_list_pool_manager_unit #(
	parameter int NODES = 256
) (
	input logic         clk,
	input logic         arst_n,
	llpm_req_if.sink    req,
	llpm_rsp_if.source  rsp
);

	localparam int IW = $clog2(NODES + 1);
	localparam int LW = $clog2(NODES);
	localparam logic [IW-1:0] SENT = IW'(NODES);

	// link memories for the real nodes
	logic [IW-1:0] next_mem [NODES];
	logic [IW-1:0] prev_mem [NODES];

	// sequencer
	logic              busy_q;
	llpm_pkg::step_t   step_q;
	llpm_pkg::ucw_t    uc;
	logic              stall;
	logic              exec;
	logic              acc;

	// list state
	logic [IW-1:0]     free_q;
	logic [IW-1:0]     size_q;
	logic [IW-1:0]     hwm_q;
	logic [IW-1:0]     head_q;
	logic [IW-1:0]     tail_q;
	logic [NODES-1:0]  live_q;

	// working registers
	logic [IW-1:0]     at_q;
	logic [IW-1:0]     n_q;
	logic [IW-1:0]     node_q;
	llpm_pkg::status_t status_q;

	// link read results
	logic              nbyp_q;
	logic [IW-1:0]     nbval_q;
	logic [IW-1:0]     ndout_q;
	logic              pbyp_q;
	logic [IW-1:0]     pbval_q;
	logic [IW-1:0]     pdout_q;
	logic [IW-1:0]     next_rd;
	logic [IW-1:0]     prev_rd;
	logic [IW-1:0]     nrd_addr;
	logic              rd_go;

	// link writes
	logic              nw_on;
	logic [IW-1:0]     nw_addr;
	logic [IW-1:0]     nw_data;
	logic              nw_mem;
	logic              nw_head;
	logic              pw_on;
	logic [IW-1:0]     pw_addr;
	logic [IW-1:0]     pw_data;
	logic              pw_mem;
	logic              pw_tail;

	// dispatch
	llpm_pkg::step_t   d_step;
	logic [IW-1:0]     d_at;
	llpm_pkg::status_t d_status;
	logic              full;
	logic              pos_live;

	logic [IW-1:0]     size_nxt;
	logic [IW-1:0]     node_nxt;

	// result register
	logic              out_valid_q;
	logic [IW-1:0]     out_node_q;
	logic [IW-1:0]     out_size_q;
	llpm_pkg::status_t out_status_q;

	assign uc    = llpm_pkg::ucode(step_q);
	assign stall = uc.last && out_valid_q && !rsp.ready;
	assign exec  = busy_q && !stall;
	assign acc   = req.valid && !busy_q;

	assign req.ready = !busy_q;

	assign rsp.valid  = out_valid_q;
	assign rsp.node   = out_node_q;
	assign rsp.size   = out_size_q;
	assign rsp.status = out_status_q;

	// ---------------- request decode and dispatch ----------------
	always_comb begin
		full     = (size_q == SENT);
		pos_live = (req.position < SENT) ? live_q[req.position[LW-1:0]] : 1'b0;
		d_step   = llpm_pkg::STEP_REPORT;
		d_at     = req.position;
		d_status = llpm_pkg::ST_OK;
		case (req.req_type)
			llpm_pkg::REQ_PUSH_BACK, llpm_pkg::REQ_PUSH_FRONT: begin
				d_at = (req.req_type == llpm_pkg::REQ_PUSH_BACK) ? SENT : head_q;
				if (full) begin
					d_status = llpm_pkg::ST_POOL_EMPTY;
				end else begin
					d_step = llpm_pkg::STEP_LINK_RD;
				end
			end
			llpm_pkg::REQ_INSERT: begin
				if (!(req.position == SENT || pos_live)) begin
					d_status = llpm_pkg::ST_BAD_POS;
				end else if (full) begin
					d_status = llpm_pkg::ST_POOL_EMPTY;
				end else begin
					d_step = llpm_pkg::STEP_LINK_RD;
				end
			end
			llpm_pkg::REQ_ERASE: begin
				if (!pos_live) begin
					d_status = llpm_pkg::ST_BAD_POS;
				end else begin
					d_step = llpm_pkg::STEP_ERASE_RD;
				end
			end
			llpm_pkg::REQ_CLEAR: begin
				if (size_q != '0) begin
					d_step = llpm_pkg::STEP_CLEAR;
				end
			end
			default: begin
				d_step = llpm_pkg::STEP_REPORT;
			end
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= llpm_pkg::STEP_REPORT;
		end else if (!busy_q) begin
			if (acc) begin
				busy_q <= 1'b1;
				step_q <= d_step;
			end
		end else if (exec) begin
			if (uc.last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= llpm_pkg::step_t'(step_q + 3'd1);
			end
		end
	end

	// ---------------- link reads ----------------
	assign rd_go    = exec && uc.rd;
	assign nrd_addr = (uc.nrd_src == llpm_pkg::NRD_AT) ? at_q : free_q;
	assign next_rd  = nbyp_q ? nbval_q : ndout_q;
	assign prev_rd  = pbyp_q ? pbval_q : pdout_q;

	// sentinel links come from registers, untouched free nodes link to i+1
	always_ff @(posedge clk) begin
		if (rd_go) begin
			nbyp_q  <= (nrd_addr == SENT) || (nrd_addr >= hwm_q);
			nbval_q <= (nrd_addr == SENT) ? head_q : nrd_addr + IW'(1);
			pbyp_q  <= (at_q == SENT);
			pbval_q <= tail_q;
		end
	end

	// ---------------- link writes ----------------
	always_comb begin
		nw_on   = 1'b1;
		nw_addr = n_q;
		case (uc.nw_addr)
			llpm_pkg::NWA_PREV_RD: nw_addr = prev_rd;
			llpm_pkg::NWA_NEW:     nw_addr = n_q;
			llpm_pkg::NWA_AT:      nw_addr = at_q;
			llpm_pkg::NWA_TAIL:    nw_addr = tail_q;
			default:               nw_on   = 1'b0;
		endcase
		case (uc.nw_data)
			llpm_pkg::NWD_NEW:     nw_data = n_q;
			llpm_pkg::NWD_AT:      nw_data = at_q;
			llpm_pkg::NWD_NEXT_RD: nw_data = next_rd;
			llpm_pkg::NWD_FREE:    nw_data = free_q;
			default:               nw_data = n_q;
		endcase
		pw_on   = 1'b1;
		pw_addr = n_q;
		case (uc.pw_addr)
			llpm_pkg::PWA_NEW:     pw_addr = n_q;
			llpm_pkg::PWA_AT:      pw_addr = at_q;
			llpm_pkg::PWA_NEXT_RD: pw_addr = next_rd;
			default:               pw_on   = 1'b0;
		endcase
		pw_data = (uc.pw_data == llpm_pkg::PWD_NEW) ? n_q : prev_rd;
		nw_mem  = exec && nw_on && (nw_addr != SENT);
		nw_head = exec && nw_on && (nw_addr == SENT);
		pw_mem  = exec && pw_on && (pw_addr != SENT);
		pw_tail = exec && pw_on && (pw_addr == SENT);
	end

	always_ff @(posedge clk) begin
		if (nw_mem) begin
			next_mem[nw_addr[LW-1:0]] <= nw_data;
		end
		if (rd_go && nrd_addr < SENT) begin
			ndout_q <= next_mem[nrd_addr[LW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pw_mem) begin
			prev_mem[pw_addr[LW-1:0]] <= pw_data;
		end
		if (rd_go && at_q < SENT) begin
			pdout_q <= prev_mem[at_q[LW-1:0]];
		end
	end

	// ---------------- list state ----------------
	always_comb begin
		size_nxt = size_q;
		if (exec) begin
			case (uc.size_op)
				llpm_pkg::SZ_INC:  size_nxt = size_q + IW'(1);
				llpm_pkg::SZ_DEC:  size_nxt = size_q - IW'(1);
				llpm_pkg::SZ_ZERO: size_nxt = '0;
				default:           size_nxt = size_q;
			endcase
		end
		node_nxt = node_q;
		case (uc.node_op)
			llpm_pkg::ND_NEW:     node_nxt = n_q;
			llpm_pkg::ND_NEXT_RD: node_nxt = next_rd;
			default:              node_nxt = node_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
			size_q <= '0;
			hwm_q  <= '0;
			head_q <= SENT;
			tail_q <= SENT;
			live_q <= '0;
		end else if (exec) begin
			size_q <= size_nxt;
			// first pop of a never used node moves the fill count on
			if (uc.take && free_q == hwm_q) begin
				hwm_q <= hwm_q + IW'(1);
			end
			case (uc.free_op)
				llpm_pkg::FH_NEXT_RD: free_q <= next_rd;
				llpm_pkg::FH_AT:      free_q <= at_q;
				llpm_pkg::FH_HEAD:    free_q <= head_q;
				default:              free_q <= free_q;
			endcase
			if (uc.sent_rst) begin
				head_q <= SENT;
				tail_q <= SENT;
			end else begin
				if (nw_head) begin
					head_q <= nw_data;
				end
				if (pw_tail) begin
					tail_q <= pw_data;
				end
			end
			case (uc.live_op)
				llpm_pkg::LV_SET_NEW: live_q[n_q[LW-1:0]]  <= 1'b1;
				llpm_pkg::LV_CLR_AT:  live_q[at_q[LW-1:0]] <= 1'b0;
				llpm_pkg::LV_CLR_ALL: live_q <= '0;
				default:              live_q <= live_q;
			endcase
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			at_q     <= d_at;
			node_q   <= SENT;
			status_q <= d_status;
		end else if (exec) begin
			node_q <= node_nxt;
			if (uc.take) begin
				n_q <= free_q;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec && uc.last) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && uc.last) begin
			out_node_q   <= node_nxt;
			out_size_q   <= size_nxt;
			out_status_q <= status_q;
		end
	end

endmodule

[dv/llpm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llpm_checker
// Watches the request and result channels of the pool manager, keeps its own
// copy of the linked list and free list, predicts each result and compares.
// ----------------------------------------------------------------------------
module llpm_checker #(
	parameter int NODES = 256
) (
	input  logic clk,
	input  logic arst_n,
	llpm_req_if  req,
	llpm_rsp_if  rsp,
	output int   failures,
	output int   pending
);
	import llpm_pkg::*;

	typedef logic [8:0] idx_t;

	typedef struct packed {
		idx_t    node;
		idx_t    size;
		status_t status;
	} outcome_t;

	localparam idx_t SENT = idx_t'(NODES);

	idx_t     next_of [NODES+1];
	idx_t     prev_of [NODES+1];
	logic     in_use  [NODES];
	idx_t     free_top;
	idx_t     list_len;
	outcome_t awaited_q[$];
	outcome_t want;

	task automatic clear_pool();
		for (int i = 0; i <= NODES; i++) begin
			next_of[i] = (i < NODES) ? idx_t'(i + 1) : SENT;
			prev_of[i] = (i < NODES) ? '0 : SENT;
		end
		for (int i = 0; i < NODES; i++)
			in_use[i] = 1'b0;
		free_top = '0;
		list_len = '0;
	endtask

	function automatic bit is_used(idx_t p);
		return p < SENT && in_use[p];
	endfunction

	function automatic idx_t pop_free();
		idx_t n;
		n = free_top;
		free_top = next_of[n];
		return n;
	endfunction

	// splice n in just ahead of at
	function automatic void link_ahead(idx_t at, idx_t n);
		idx_t p;
		p = prev_of[at];
		next_of[p] = n;
		prev_of[n] = p;
		prev_of[at] = n;
		next_of[n] = at;
		if (n < SENT)
			in_use[n] = 1'b1;
		list_len++;
	endfunction

	function automatic outcome_t apply_request(logic [2:0] code, idx_t pos);
		outcome_t o;
		idx_t     nx, pv, tail;
		o.node   = SENT;
		o.status = ST_OK;
		case (code)
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (list_len >= SENT) begin
					o.status = ST_POOL_EMPTY;
				end else begin
					o.node = pop_free();
					link_ahead(code == REQ_PUSH_BACK ? SENT : next_of[SENT], o.node);
				end
			end
			REQ_INSERT: begin
				if (!(pos == SENT || is_used(pos))) begin
					o.status = ST_BAD_POS;
				end else if (list_len >= SENT) begin
					o.status = ST_POOL_EMPTY;
				end else begin
					o.node = pop_free();
					link_ahead(pos, o.node);
				end
			end
			REQ_ERASE: begin
				if (!is_used(pos)) begin
					o.status = ST_BAD_POS;
				end else begin
					nx = next_of[pos];
					pv = prev_of[pos];
					next_of[pv] = nx;
					prev_of[nx] = pv;
					next_of[pos] = free_top;
					free_top = pos;
					in_use[pos] = 1'b0;
					list_len--;
					o.node = nx;
				end
			end
			REQ_CLEAR: begin
				if (list_len != 0) begin
					tail = prev_of[SENT];
					next_of[tail] = free_top;
					free_top = next_of[SENT];
					next_of[SENT] = SENT;
					prev_of[SENT] = SENT;
					list_len = '0;
					for (int i = 0; i < NODES; i++)
						in_use[i] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		o.size = list_len;
		return o;
	endfunction

	task automatic note_failure(string what);
		failures++;
		if (failures <= 10)
			$display("%0t ns: result mismatch: %s", $time, what);
	endtask

	task automatic check_field(string field, idx_t exp_v, idx_t got_v);
		if (got_v !== exp_v)
			note_failure($sformatf("%s expected %0d, got %0d", field, exp_v, got_v));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_pool();
			awaited_q.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_q.size() == 0) begin
					note_failure($sformatf("unexpected beat node %0d size %0d status %0d",
						rsp.node, rsp.size, rsp.status));
				end else begin
					want = awaited_q.pop_front();
					check_field("node", want.node, rsp.node);
					check_field("size", want.size, rsp.size);
					check_field("status", idx_t'(want.status), idx_t'(rsp.status));
				end
			end
			if (req.valid && req.ready)
				awaited_q.push_back(apply_request(req.req_type, req.position));
			pending <= awaited_q.size();
		end
	end

endmodule

[dv/linked_list_pool_manager_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_pool_manager_unit_test
// Drives requests into the pool manager with random gaps and back-pressure:
// a directed opening, a fill to a full pool, then random episodes of growth,
// churn, draining, clears and malformed requests. The checker judges results.
// ----------------------------------------------------------------------------
module linked_list_pool_manager_unit_test;
	import llpm_pkg::*;

	localparam int         NODES        = 256;
	localparam logic [8:0] SENT         = 9'(NODES);
	localparam int         TOTAL_ITEMS  = 450;
	localparam int         LONG_HOLD    = 200;
	localparam logic [2:0] REQ_SPARE_A  = 3'd5;
	localparam logic [2:0] REQ_SPARE_B  = 3'd6;
	localparam logic [2:0] REQ_SPARE_C  = 3'd7;

	logic       clk;
	logic       arst_n;
	int         failures;
	int         pending;
	int         sent;
	int         beats;
	bit         no_idle;
	bit         rx_no_idle;
	logic [8:0] last_size;
	logic [8:0] known_nodes[$];

	llpm_req_if #(.IDX_W(9)) req ();
	llpm_rsp_if #(.IDX_W(9)) rsp ();

	linked_list_pool_manager_unit #(.NODES(NODES)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	llpm_checker #(.NODES(NODES)) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.failures (failures),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [8:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75 && known_nodes.size() > 0)
			return known_nodes[$urandom_range(0, known_nodes.size() - 1)];
		if (r < 85)
			return SENT;
		return 9'($urandom_range(0, NODES - 1));
	endfunction

	task automatic send(input logic [2:0] code, input logic [8:0] pos);
		int g;
		g = pick_gap(no_idle);
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.req_type <= code;
		req.position <= pos;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	task automatic send_link();
		case ($urandom_range(0, 2))
			0: send(REQ_PUSH_BACK, 9'($urandom_range(0, 511)));
			1: send(REQ_PUSH_FRONT, 9'($urandom_range(0, 511)));
			default: send(REQ_INSERT, pick_position());
		endcase
	endtask

	// hold the request side until every result is back
	task automatic quiesce();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// result side: random ready, with two long hold-offs to back the block up
	initial begin
		int g;
		rsp.ready <= 1'b0;
		beats = 0;
		rx_no_idle = 1'b0;
		last_size = '0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (beats % 64 == 0)
				rx_no_idle = ($urandom_range(0, 3) == 0);
			g = (beats == 30 || beats == 200) ? LONG_HOLD : pick_gap(rx_no_idle);
			if (g > 0) begin
				rsp.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			beats++;
			last_size = rsp.size;
			if (rsp.size == 0)
				known_nodes.delete();
			if (rsp.status == ST_OK && rsp.node < SENT) begin
				known_nodes.push_back(rsp.node);
				if (known_nodes.size() > 64)
					void'(known_nodes.pop_front());
			end
		end
	end

	initial begin
		int         n;
		logic [8:0] live_pos;
		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.req_type <= REQ_PUSH_BACK;
		req.position <= '0;
		sent = 0;
		no_idle = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: erases and inserts are bad positions, then pushes start a list
		send(REQ_ERASE, 9'd0);
		send(REQ_ERASE, SENT);
		send(REQ_ERASE, 9'd511);
		send(REQ_INSERT, 9'd5);
		send(REQ_INSERT, 9'd300);
		send(REQ_CLEAR, 9'd0);
		send(REQ_PUSH_BACK, 9'd511);
		send(REQ_PUSH_FRONT, 9'd0);
		send(REQ_INSERT, SENT);
		send(REQ_INSERT, 9'd0);
		send(REQ_ERASE, 9'd1);
		// tail erase reports the sentinel as successor
		send(REQ_ERASE, 9'd2);
		send(REQ_SPARE_A, 9'd511);
		send(REQ_SPARE_B, 9'd0);
		send(REQ_SPARE_C, SENT);
		send(REQ_CLEAR, 9'd170);
		send(REQ_PUSH_BACK, 9'd85);
		send(REQ_ERASE, 9'd0);
		send(REQ_ERASE, 9'd3);

		// fill the pool and run past full
		n = 0;
		while (last_size < SENT && n < 320) begin
			send_link();
			n++;
		end
		quiesce();
		live_pos = (known_nodes.size() > 0) ? known_nodes[$] : 9'd0;
		send(REQ_PUSH_BACK, 9'd0);
		send(REQ_PUSH_FRONT, 9'd511);
		send(REQ_INSERT, SENT);
		// bad position wins over a full pool
		send(REQ_INSERT, 9'd400);
		send(REQ_INSERT, 9'd257);
		send(REQ_INSERT, live_pos);
		send(REQ_ERASE, live_pos);
		send(REQ_PUSH_BACK, 9'd256);
		send(REQ_ERASE, SENT);

		while (sent < TOTAL_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			n = $urandom_range(4, 30);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat (n) send_link();
				end
				3, 4, 5: begin
					repeat (n) begin
						if ($urandom_range(0, 1) == 0)
							send(REQ_ERASE, pick_position());
						else
							send_link();
					end
				end
				6: begin
					repeat (n) send(REQ_ERASE, pick_position());
				end
				7: begin
					send(REQ_CLEAR, 9'($urandom_range(0, 511)));
				end
				default: begin
					repeat (n / 3 + 1)
						send(3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)));
				end
			endcase
		end

		quiesce();
		repeat (20) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
sv/llpm_pkg.sv
sv/llpm_req_if.sv
sv/llpm_rsp_if.sv
sv/linked_list_pool_manager_unit.sv
dv/llpm_checker.sv
dv/linked_list_pool_manager_unit_test.sv
